@@ hw/rtl/gclru_pkg.sv @@
package gclru_pkg;

  // cache geometry
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned CODE_BITS  = 16;
  localparam int unsigned IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W      = IDX_W + 1;

  // port field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CHAR_W     = 16;
  localparam int unsigned OUT_IDX_W  = 6;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INVAL  = 2'd1,
    CMD_PROBE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one tag store entry as held in memory
  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp;
    logic [CODE_BITS-1:0]  code;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/glyph_cache_lru_lookup.sv @@
// channel   | dir | tdata                                    | tuser
// ----------+-----+------------------------------------------+---------------
// s_axis    | in  | [15:0] char_code                         | [1:0] command
// m_axis    | out | [0] present, [6:1] slot_index,           | none
//           |     | [7] evicted, [23:8] evicted_code         |
//
// a word is accepted only in idle; the next one waits until the sweep and the
// write-back of this one are done and its result is registered for m_axis.
// the tag store memory is swept one entry per cycle through its single
// read port, then a lookup writes its updated entry back.
// the next word is taken while a finished result waits on m_axis.
// reset clears valid bits and the use counter at once; no clearing pass.
module glyph_cache_lru_lookup
  import gclru_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [15:0] char_code
  input  logic [CMD_W-1:0]      s_axis_tuser_i,   // [1:0] command
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // present, slot_index, evicted, evicted_code
);

  state_e state_q, state_d;

  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [CODE_BITS-1:0]  code_q, code_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [STAMP_BITS-1:0] best_stamp_q, best_stamp_d;
  logic                  best_vld_q, best_vld_d;
  logic [CODE_BITS-1:0]  best_code_q, best_code_d;
  logic [STAMP_BITS-1:0] use_cnt_q, use_cnt_d;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic                  out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                  in_fire;
  logic                  scan_re;
  logic                  done_fire;
  logic                  scan_last;
  logic                  out_free;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                ent;
  logic                  ent_vld;
  logic [CODE_BITS-1:0]  ent_code;
  logic [STAMP_BITS-1:0] ent_stamp;

  // tag store: code and stamp per slot
  gclru_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (scan_re),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign scan_last = rd_vld_q && (rd_idx_q == IDX_W'(SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_last) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    scan_re         = 1'b0;
    done_fire       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_SCAN: scan_re = (cnt_q < CNT_W'(SLOTS));
      ST_DONE: done_fire = out_free;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // entry under inspection; a free slot reads as code and stamp zero
  assign ent       = entry_t'(ram_rdata);
  assign ent_vld   = valid_q[rd_idx_q];
  assign ent_code  = ent_vld ? ent.code : '0;
  assign ent_stamp = ent_vld ? ent.stamp : '0;

  // item capture and scan bookkeeping
  always_comb begin
    cmd_d        = cmd_q;
    code_d       = code_q;
    cnt_d        = cnt_q;
    rd_vld_d     = scan_re;
    rd_idx_d     = cnt_q[IDX_W-1:0];
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    best_vld_d   = best_vld_q;
    best_code_d  = best_code_q;
    if (in_fire) begin
      cmd_d     = s_axis_tuser_i;
      code_d    = CODE_BITS'(s_axis_tdata_i[CHAR_W-1:0]);
      cnt_d     = '0;
      hit_d     = 1'b0;
      hit_idx_d = '0;
    end
    if (scan_re) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (rd_vld_q) begin
      // first valid slot with the code
      if (!hit_q && ent_vld && (ent.code == code_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_q;
      end
      // oldest stamp, lowest index on ties
      if ((rd_idx_q == '0) || (ent_stamp < best_stamp_q)) begin
        best_idx_d   = rd_idx_q;
        best_stamp_d = ent_stamp;
        best_vld_d   = ent_vld;
        best_code_d  = ent_code;
      end
    end
  end

  // write back, valid bits, counter and result
  always_comb begin
    logic                 present;
    logic [IDX_W-1:0]     idx;
    logic                 evicted;
    logic [CODE_BITS-1:0] ev_code;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = '{stamp: use_cnt_q, code: code_q};
    valid_d    = valid_q;
    use_cnt_d  = use_cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    present    = hit_q;
    idx        = hit_idx_q;
    evicted    = 1'b0;
    ev_code    = '0;
    if (done_fire) begin
      unique case (cmd_e'(cmd_q))
        CMD_LOOKUP: begin
          ram_we    = 1'b1;
          use_cnt_d = use_cnt_q + STAMP_BITS'(1);
          if (!hit_q) begin
            ram_waddr           = best_idx_q;
            idx                 = best_idx_q;
            valid_d[best_idx_q] = 1'b1;
            evicted             = best_vld_q;
            ev_code             = best_code_q;
          end
        end
        CMD_INVAL: begin
          if (hit_q) valid_d[hit_idx_q] = 1'b0;
        end
        default: ;
      endcase
      out_vld_d  = 1'b1;
      out_data_d = {CHAR_W'(ev_code), evicted, OUT_IDX_W'(idx), present};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      use_cnt_q <= '0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      use_cnt_q <= use_cnt_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    code_q       <= code_d;
    rd_idx_q     <= rd_idx_d;
    hit_idx_q    <= hit_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_vld_q   <= best_vld_d;
    best_code_q  <= best_code_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // a new result only comes out of the write-back cycle
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a write-back cycle");

  // an accepted word always starts a sweep of the tag store at slot zero
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SCAN) && (cnt_q == CNT_W'(0)))
    else $error("accepted word did not start a sweep");

  // the use counter moves only on a lookup write-back
  a_counter_on_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (use_cnt_q != $past(use_cnt_q)) |->
      $past(done_fire && (cmd_q == CMD_LOOKUP)))
    else $error("use counter changed outside a lookup");

  // the memory is written only when a result is produced
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_vld_q)
    else $error("tag store written without a result");
`endif

endmodule

@@ hw/rtl/gclru_ram.sv @@
module gclru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
